// ----- sv/sng_pkg.sv -----
// ----------------------------------------------------------------------------
// Stereo noise gate package
// Widths, register indexes, reset values, the controller-to-datapath command
// and status types, and the rounding and saturation of the output mix.
// ----------------------------------------------------------------------------
package sng_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int COEF_WIDTH   = 16;

	localparam int THR_W      = 15;
	localparam int LEVEL_W    = 16;
	localparam int LEVEL_FRAC = 15;
	localparam int CFG_DATA_W = (COEF_WIDTH > LEVEL_W) ? COEF_WIDTH : LEVEL_W;
	localparam int CFG_IDX_W  = 3;

	localparam int GAIN_W   = COEF_WIDTH + 1;
	localparam int MAG_W    = SAMPLE_WIDTH;
	localparam int ENERGY_W = 2 * SAMPLE_WIDTH;
	localparam int TH_W     = SAMPLE_WIDTH - 1;
	localparam int TH_UP    = (SAMPLE_WIDTH >= 16) ? SAMPLE_WIDTH - 16 : 0;
	localparam int TH_DN    = (SAMPLE_WIDTH < 16) ? 16 - SAMPLE_WIDTH : 0;
	localparam int LIMIT_W  = 2 * TH_W + 1;
	localparam int STEP_W   = 2 * COEF_WIDTH + 2;
	localparam int WET_W    = GAIN_W + LEVEL_W;
	localparam int K_W      = WET_W + 2;
	localparam int MIX_W    = LEVEL_W + 2;

	localparam int MUL_W0 = (SAMPLE_WIDTH > GAIN_W) ? SAMPLE_WIDTH : GAIN_W;
	localparam int MUL_W  = ((MUL_W0 > MIX_W) ? MUL_W0 : MIX_W) + 1;
	localparam int PROD_W = 2 * MUL_W;

	localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(1) << COEF_WIDTH;
	localparam logic signed [PROD_W-1:0] MIX_ROUND = PROD_W'(1) << (LEVEL_FRAC - 1);

	typedef logic [CFG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_THRESHOLD = 3'd0;
	localparam reg_idx_t REG_ATTACK    = 3'd1;
	localparam reg_idx_t REG_RELEASE   = 3'd2;
	localparam reg_idx_t REG_WET       = 3'd3;
	localparam reg_idx_t REG_DRY       = 3'd4;

	localparam logic [THR_W-1:0]      THRESHOLD_RST = THR_W'(1638);
	localparam logic [COEF_WIDTH-1:0] ATTACK_RST    = COEF_WIDTH'(65216);
	localparam logic [COEF_WIDTH-1:0] RELEASE_RST   = COEF_WIDTH'(65531);
	localparam logic [LEVEL_W-1:0]    WET_RST       = LEVEL_W'(32768);
	localparam logic [LEVEL_W-1:0]    DRY_RST       = LEVEL_W'(0);

	typedef logic [2:0] mul_sel_t;
	localparam mul_sel_t MS_THR     = 3'd0;
	localparam mul_sel_t MS_SQL     = 3'd1;
	localparam mul_sel_t MS_SQR     = 3'd2;
	localparam mul_sel_t MS_ATTACK  = 3'd3;
	localparam mul_sel_t MS_RELEASE = 3'd4;
	localparam mul_sel_t MS_WET     = 3'd5;
	localparam mul_sel_t MS_MIXL    = 3'd6;
	localparam mul_sel_t MS_MIXR    = 3'd7;

	typedef struct packed {
		logic [THR_W-1:0]      threshold;
		logic [COEF_WIDTH-1:0] attack_coef;
		logic [COEF_WIDTH-1:0] release_coef;
		logic [LEVEL_W-1:0]    wet_level;
		logic [LEVEL_W-1:0]    dry_level;
	} sng_cfg_t;

	typedef struct packed {
		logic     load_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     load_limit;
		logic     load_energy;
		logic     load_above;
		logic     load_gain;
		logic     load_mult;
		logic     load_left;
		logic     load_out;
	} sng_cmd_t;

	typedef struct packed {
		logic above;
	} sng_stat_t;

	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_mix(
		input logic signed [PROD_W-1:0] p
	);
		logic signed [PROD_W-1:0] r;
		logic [PROD_W-SAMPLE_WIDTH:0] top;
		r   = (p + MIX_ROUND) >>> LEVEL_FRAC;
		top = r[PROD_W-1:SAMPLE_WIDTH-1];
		if (top == '0 || top == '1) begin
			return $signed(r[SAMPLE_WIDTH-1:0]);
		end else if (r[PROD_W-1]) begin
			return $signed({1'b1, {(SAMPLE_WIDTH-1){1'b0}}});
		end else begin
			return $signed({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
		end
	endfunction

endpackage

// ----- sv/sng_if.sv -----
// ----------------------------------------------------------------------------
// Stereo noise gate channel interfaces
// Valid/ready channels for sample pairs, gated results and register writes.
// ----------------------------------------------------------------------------
interface sng_pair_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [sng_pkg::SAMPLE_WIDTH-1:0] left_sample;
	logic signed [sng_pkg::SAMPLE_WIDTH-1:0] right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

interface sng_out_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [sng_pkg::SAMPLE_WIDTH-1:0] left_out;
	logic signed [sng_pkg::SAMPLE_WIDTH-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink (input valid, input left_out, input right_out, output ready);
endinterface

interface sng_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [sng_pkg::CFG_IDX_W-1:0]         index;
	logic [sng_pkg::CFG_DATA_W-1:0]        data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/stereo_noise_gate.sv -----
// ----------------------------------------------------------------------------
// Stereo noise gate
// Attack/release noise gate with wet/dry mix on Q1.15 stereo sample pairs.
// ----------------------------------------------------------------------------
// A sample pair passes from its transaction on the input to the result standing
// in the output register, and the next pair is accepted in the cycle after
// that. The pair is sequenced through a single shared 19 x 19 signed
// multiplier, which forms seven products per pair in turn (threshold square,
// two channel squares, gain step, wet gain, two channel mixes) around the
// level compare and the gain update. A finished result waits in the output
// register without blocking the next input transaction; only when the next
// result is also finished does the controller hold it and stop taking input.
// Registers are written through the configuration channel, which is always
// ready, and should be written only while no pair is in flight.
module stereo_noise_gate (
	input  logic      clk,
	input  logic      arst_n,
	sng_pair_if.sink  samples,
	sng_out_if.source results,
	sng_cfg_if.sink   cfg
);
	import sng_pkg::*;

	sng_cfg_t  regs;
	sng_cmd_t  cmd;
	sng_stat_t stat;

	sng_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	sng_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sng_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.regs      (regs),
		.in_left   (samples.left_sample),
		.in_right  (samples.right_sample),
		.stat      (stat),
		.left_out  (results.left_out),
		.right_out (results.right_out)
	);

endmodule

// ----- sv/sng_regs.sv -----
// ----------------------------------------------------------------------------
// Stereo noise gate register file
// Holds threshold, attack and release coefficients and the wet and dry levels.
// ----------------------------------------------------------------------------
module sng_regs (
	input  logic              clk,
	input  logic              arst_n,
	sng_cfg_if.sink           cfg,
	output sng_pkg::sng_cfg_t regs
);
	import sng_pkg::*;

	sng_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.threshold    <= THRESHOLD_RST;
			regs_q.attack_coef  <= ATTACK_RST;
			regs_q.release_coef <= RELEASE_RST;
			regs_q.wet_level    <= WET_RST;
			regs_q.dry_level    <= DRY_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_THRESHOLD: regs_q.threshold    <= cfg.data[THR_W-1:0];
				REG_ATTACK:    regs_q.attack_coef  <= cfg.data[COEF_WIDTH-1:0];
				REG_RELEASE:   regs_q.release_coef <= cfg.data[COEF_WIDTH-1:0];
				REG_WET:       regs_q.wet_level    <= cfg.data[LEVEL_W-1:0];
				REG_DRY:       regs_q.dry_level    <= cfg.data[LEVEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- sv/sng_datapath.sv -----
// ----------------------------------------------------------------------------
// Stereo noise gate datapath
// One shared signed multiplier with its product register, the level compare,
// the gain state, the mix factor and the output registers.
// ----------------------------------------------------------------------------
module sng_datapath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  sng_pkg::sng_cmd_t                       cmd,
	input  sng_pkg::sng_cfg_t                       regs,
	input  logic signed [sng_pkg::SAMPLE_WIDTH-1:0] in_left,
	input  logic signed [sng_pkg::SAMPLE_WIDTH-1:0] in_right,
	output sng_pkg::sng_stat_t                      stat,
	output logic signed [sng_pkg::SAMPLE_WIDTH-1:0] left_out,
	output logic signed [sng_pkg::SAMPLE_WIDTH-1:0] right_out
);
	import sng_pkg::*;

	logic signed [SAMPLE_WIDTH-1:0] left_q, right_q;
	logic signed [SAMPLE_WIDTH-1:0] left_res_q, left_out_q, right_out_q;
	logic signed [PROD_W-1:0]       prod_q, prod;
	logic signed [MUL_W-1:0]        mul_a, mul_b;
	logic [LIMIT_W-1:0]             limit_q;
	logic [ENERGY_W-1:0]            energy_q, energy_sum;
	logic                           above_q;
	logic [GAIN_W-1:0]              gain_q, gain_next;
	logic [MIX_W-1:0]               mult_q, mult_next;
	logic [MAG_W-1:0]               mag_l, mag_r;
	logic [THR_W+TH_UP-1:0]         th_wide;
	logic [TH_W-1:0]                th;
	logic [STEP_W-1:0]              step_up;
	logic [GAIN_W:0]                gain_sum;
	logic [K_W-1:0]                 k_full;

	assign mag_l   = left_q[SAMPLE_WIDTH-1] ? $unsigned(-left_q) : $unsigned(left_q);
	assign mag_r   = right_q[SAMPLE_WIDTH-1] ? $unsigned(-right_q) : $unsigned(right_q);
	assign th_wide = (THR_W + TH_UP)'(regs.threshold) << TH_UP;
	assign th      = TH_W'(th_wide >> TH_DN);

	always_comb begin
		case (cmd.mul_sel)
			MS_THR: begin
				mul_a = MUL_W'(th);
				mul_b = MUL_W'(th);
			end
			MS_SQL: begin
				mul_a = MUL_W'(mag_l);
				mul_b = MUL_W'(mag_l);
			end
			MS_SQR: begin
				mul_a = MUL_W'(mag_r);
				mul_b = MUL_W'(mag_r);
			end
			MS_ATTACK: begin
				mul_a = MUL_W'(UNITY - gain_q);
				mul_b = MUL_W'(UNITY - GAIN_W'(regs.attack_coef));
			end
			MS_RELEASE: begin
				mul_a = MUL_W'(gain_q);
				mul_b = MUL_W'(regs.release_coef);
			end
			MS_WET: begin
				mul_a = MUL_W'(gain_q);
				mul_b = MUL_W'(regs.wet_level);
			end
			MS_MIXL: begin
				mul_a = MUL_W'(left_q);
				mul_b = MUL_W'(mult_q);
			end
			MS_MIXR: begin
				mul_a = MUL_W'(right_q);
				mul_b = MUL_W'(mult_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	assign energy_sum = energy_q + prod_q[ENERGY_W-1:0];

	// The attack step is rounded up, the release product is truncated.
	assign step_up = STEP_W'(prod_q[2*COEF_WIDTH:0]) + STEP_W'(UNITY - 1'b1);
	always_comb begin
		if (above_q) begin
			gain_sum = (GAIN_W + 1)'(gain_q) + step_up[STEP_W-1:COEF_WIDTH];
		end else begin
			gain_sum = (GAIN_W + 1)'(prod_q[2*COEF_WIDTH:COEF_WIDTH]);
		end
		if (gain_sum > (GAIN_W + 1)'(UNITY)) begin
			gain_next = UNITY;
		end else begin
			gain_next = gain_sum[GAIN_W-1:0];
		end
	end

	// Gain times wet level times 1.5, back to Q.15 with rounding half up.
	assign k_full    = K_W'(prod_q[WET_W-1:0]) + K_W'({prod_q[WET_W-1:0], 1'b0}) + K_W'(UNITY);
	assign mult_next = k_full[K_W-1:COEF_WIDTH+1] + MIX_W'(regs.dry_level);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			left_q  <= in_left;
			right_q <= in_right;
		end
		if (cmd.mul_en) begin
			prod_q <= prod;
		end
		if (cmd.load_limit) begin
			limit_q <= {prod_q[2*TH_W-1:0], 1'b0};
		end
		if (cmd.load_energy) begin
			energy_q <= prod_q[ENERGY_W-1:0];
		end
		if (cmd.load_above) begin
			above_q <= energy_sum > ENERGY_W'(limit_q);
		end
		if (cmd.load_mult) begin
			mult_q <= mult_next;
		end
		if (cmd.load_left) begin
			left_res_q <= sat_mix(prod_q);
		end
		if (cmd.load_out) begin
			left_out_q  <= left_res_q;
			right_out_q <= sat_mix(prod_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
		end else if (cmd.load_gain) begin
			gain_q <= gain_next;
		end
	end

	assign stat.above = above_q;
	assign left_out   = left_out_q;
	assign right_out  = right_out_q;

endmodule

// ----- sv/sng_ctrl.sv -----
// ----------------------------------------------------------------------------
// Stereo noise gate controller
// Sequences one sample pair through the shared multiplier and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module sng_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  sng_pkg::sng_stat_t stat,
	output sng_pkg::sng_cmd_t  cmd
);
	import sng_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_THR  = 4'd1;
	localparam logic [3:0] ST_SQL  = 4'd2;
	localparam logic [3:0] ST_SQR  = 4'd3;
	localparam logic [3:0] ST_CMP  = 4'd4;
	localparam logic [3:0] ST_GAIN = 4'd5;
	localparam logic [3:0] ST_GUPD = 4'd6;
	localparam logic [3:0] ST_WET  = 4'd7;
	localparam logic [3:0] ST_MULT = 4'd8;
	localparam logic [3:0] ST_MIXL = 4'd9;
	localparam logic [3:0] ST_MIXR = 4'd10;
	localparam logic [3:0] ST_DONE = 4'd11;

	logic [3:0] state_q, state_next;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_next = ST_THR;
				end
			end
			ST_THR: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_THR;
				state_next  = ST_SQL;
			end
			ST_SQL: begin
				cmd.mul_en     = 1'b1;
				cmd.mul_sel    = MS_SQL;
				cmd.load_limit = 1'b1;
				state_next     = ST_SQR;
			end
			ST_SQR: begin
				cmd.mul_en      = 1'b1;
				cmd.mul_sel     = MS_SQR;
				cmd.load_energy = 1'b1;
				state_next      = ST_CMP;
			end
			ST_CMP: begin
				cmd.load_above = 1'b1;
				state_next     = ST_GAIN;
			end
			ST_GAIN: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = stat.above ? MS_ATTACK : MS_RELEASE;
				state_next  = ST_GUPD;
			end
			ST_GUPD: begin
				cmd.load_gain = 1'b1;
				state_next    = ST_WET;
			end
			ST_WET: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_WET;
				state_next  = ST_MULT;
			end
			ST_MULT: begin
				cmd.load_mult = 1'b1;
				state_next    = ST_MIXL;
			end
			ST_MIXL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_MIXL;
				state_next  = ST_MIXR;
			end
			ST_MIXR: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = MS_MIXR;
				cmd.load_left = 1'b1;
				state_next    = ST_DONE;
			end
			ST_DONE: begin
				cmd.load_out = out_free;
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/sng_checker.sv -----
// ----------------------------------------------------------------------------
// Stereo noise gate port checker
// Watches the sample and result channels of the top level over time.
// ----------------------------------------------------------------------------
module sng_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [2*sng_pkg::SAMPLE_WIDTH-1:0] out_data
);
	import sng_pkg::*;

	logic [1:0] pending_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Pairs accepted whose result transaction has not yet happened.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before its transaction");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("stalled result changed");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result offered with no pair outstanding");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> pending_q != 2'd2)
		else $error("pair accepted while one is in work and one waits");

endmodule

bind stereo_noise_gate sng_checker u_sng_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  ({results.left_out, results.right_out})
);
